// File: src/smeu_pkg.sv
`default_nettype none
package smeu_pkg;

  localparam int DATA_STACK_DEPTH   = 256;
  localparam int RETURN_STACK_DEPTH = 256;
  localparam int MEMORY_WORDS       = 2048;

  localparam int WORD_W  = 32;
  localparam int DEPTH_W = 9;

  localparam logic [31:0] IO_BASE     = 32'hFE000000;
  localparam logic [31:0] IO_TX       = IO_BASE + 32'h0;
  localparam logic [31:0] IO_RX       = IO_BASE + 32'h4;
  localparam logic [31:0] IO_STAT     = IO_BASE + 32'h8;
  localparam logic [31:0] IO_TCMP     = IO_BASE + 32'h1004;
  localparam logic [31:0] IO_TCTRL    = IO_BASE + 32'h1008;
  localparam logic [31:0] FRAME_ADDR  = 32'h10000;
  localparam logic [31:0] TRAP_OFFSET = 32'h10;
  localparam logic [31:0] ST_KM       = 32'h1;
  localparam logic [31:0] ST_UM       = 32'h2;

  localparam logic [1:0] RUN_GO   = 2'd0;
  localparam logic [1:0] RUN_HALT = 2'd1;
  localparam logic [1:0] RUN_END  = 2'd2;

  localparam logic [2:0] F_NONE    = 3'd0;
  localparam logic [2:0] F_DOVER   = 3'd1;
  localparam logic [2:0] F_DUNDER  = 3'd2;
  localparam logic [2:0] F_ROVER   = 3'd3;
  localparam logic [2:0] F_RUNDER  = 3'd4;
  localparam logic [2:0] F_ILLEGAL = 3'd5;
  localparam logic [2:0] F_IMM     = 3'd6;

  localparam logic [7:0] OP_PUSH     = 8'h01;
  localparam logic [7:0] OP_ADD      = 8'h02;
  localparam logic [7:0] OP_SUB      = 8'h03;
  localparam logic [7:0] OP_MUL      = 8'h04;
  localparam logic [7:0] OP_DROP     = 8'h05;
  localparam logic [7:0] OP_PRINT    = 8'h08;
  localparam logic [7:0] OP_EQ       = 8'h09;
  localparam logic [7:0] OP_LT       = 8'h0A;
  localparam logic [7:0] OP_GT       = 8'h0B;
  localparam logic [7:0] OP_LTU      = 8'h0C;
  localparam logic [7:0] OP_GTU      = 8'h0D;
  localparam logic [7:0] OP_JNZ      = 8'h0E;
  localparam logic [7:0] OP_JMP      = 8'h0F;
  localparam logic [7:0] OP_CALL     = 8'h10;
  localparam logic [7:0] OP_RET      = 8'h11;
  localparam logic [7:0] OP_DUP      = 8'h12;
  localparam logic [7:0] OP_SWAP     = 8'h13;
  localparam logic [7:0] OP_OVER     = 8'h14;
  localparam logic [7:0] OP_ROT      = 8'h15;
  localparam logic [7:0] OP_AND      = 8'h16;
  localparam logic [7:0] OP_OR       = 8'h17;
  localparam logic [7:0] OP_XOR      = 8'h18;
  localparam logic [7:0] OP_NOT      = 8'h19;
  localparam logic [7:0] OP_SHL      = 8'h1A;
  localparam logic [7:0] OP_SHR      = 8'h1B;
  localparam logic [7:0] OP_SAR      = 8'h1C;
  localparam logic [7:0] OP_LOAD     = 8'h1D;
  localparam logic [7:0] OP_STORE    = 8'h1E;
  localparam logic [7:0] OP_KEY      = 8'h1F;
  localparam logic [7:0] OP_TOR      = 8'h30;
  localparam logic [7:0] OP_FROMR    = 8'h31;
  localparam logic [7:0] OP_RFETCH   = 8'h32;
  localparam logic [7:0] OP_DEPTH    = 8'h33;
  localparam logic [7:0] OP_RDEPTH   = 8'h34;
  localparam logic [7:0] OP_EQZ      = 8'h35;
  localparam logic [7:0] OP_DIV      = 8'h36;
  localparam logic [7:0] OP_LOADB    = 8'h37;
  localparam logic [7:0] OP_STOREB   = 8'h38;
  localparam logic [7:0] OP_LDL      = 8'h39;
  localparam logic [7:0] OP_STL      = 8'h3A;
  localparam logic [7:0] OP_SYSENTER = 8'h3B;
  localparam logic [7:0] OP_ERET     = 8'h3C;
  localparam logic [7:0] OP_CSRR     = 8'h3D;
  localparam logic [7:0] OP_CSRW     = 8'h3E;
  localparam logic [7:0] OP_NOP      = 8'h3F;
  localparam logic [7:0] OP_GETFP    = 8'h40;
  localparam logic [7:0] OP_CALLI    = 8'h48;
  localparam logic [7:0] OP_SETFP    = 8'h49;
  localparam logic [7:0] OP_HALT     = 8'hFF;

  typedef enum logic [1:0] {IMM_NONE, IMM_32, IMM_8} imm_kind_t;

  typedef struct packed {
    logic      legal;
    imm_kind_t imm;
    logic [1:0] dp;
    logic [1:0] dq;
    logic      rp;
    logic      rq;
  } op_info_t;

  function automatic op_info_t op_decode(input logic [7:0] op);
    op_info_t i;
    i = '{legal: 1'b1, imm: IMM_NONE, dp: 2'd0, dq: 2'd0, rp: 1'b0, rq: 1'b0};
    case (op)
      OP_SYSENTER, OP_ERET, OP_NOP, OP_HALT: ;
      OP_PUSH:  begin i.imm = IMM_32; i.dq = 2'd1; end
      OP_JNZ:   begin i.imm = IMM_32; i.dp = 2'd1; end
      OP_JMP:   i.imm = IMM_32;
      OP_CALL:  begin i.imm = IMM_32; i.rq = 1'b1; end
      OP_CSRR:  begin i.imm = IMM_32; i.dq = 2'd1; end
      OP_CSRW:  begin i.imm = IMM_32; i.dp = 2'd1; end
      OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LT, OP_GT, OP_LTU, OP_GTU, OP_AND, OP_OR,
      OP_XOR, OP_SHL, OP_SHR, OP_SAR, OP_DIV, OP_STORE, OP_STOREB: begin
        i.dp = 2'd2; i.dq = 2'd1;
      end
      OP_NOT, OP_EQZ, OP_LOAD, OP_LOADB: begin i.dp = 2'd1; i.dq = 2'd1; end
      OP_DROP, OP_PRINT, OP_SETFP: i.dp = 2'd1;
      OP_DUP:   begin i.dp = 2'd1; i.dq = 2'd2; end
      OP_OVER:  begin i.dp = 2'd2; i.dq = 2'd3; end
      OP_SWAP:  begin i.dp = 2'd2; i.dq = 2'd2; end
      OP_ROT:   begin i.dp = 2'd3; i.dq = 2'd3; end
      OP_KEY, OP_DEPTH, OP_RDEPTH, OP_GETFP: i.dq = 2'd1;
      OP_TOR, OP_CALLI: begin i.dp = 2'd1; i.rq = 1'b1; end
      OP_FROMR: begin i.rp = 1'b1; i.dq = 2'd1; end
      OP_RFETCH: begin i.rp = 1'b1; i.rq = 1'b1; i.dq = 2'd1; end
      OP_RET:   i.rp = 1'b1;
      OP_LDL:   begin i.imm = IMM_8; i.dq = 2'd1; end
      OP_STL:   begin i.imm = IMM_8; i.dp = 2'd1; end
      default:  i.legal = 1'b0;
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

// File: src/smeu_if.sv
`default_nettype none
interface smeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [31:0] immediate;
  logic       rx_available;
  logic [7:0] rx_byte;
  modport source(output valid, opcode, immediate, rx_available, rx_byte, input ready);
  modport sink(input valid, opcode, immediate, rx_available, rx_byte, output ready);
endinterface

interface smeu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  run_state;
  logic [2:0]  fault_code;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        rx_taken;
  logic        frame_sync;
  logic [31:0] top_value;
  logic [8:0]  stack_depth;
  modport source(output valid, next_pc, run_state, fault_code, tx_valid, tx_byte, rx_taken,
                 frame_sync, top_value, stack_depth, input ready);
  modport sink(input valid, next_pc, run_state, fault_code, tx_valid, tx_byte, rx_taken,
               frame_sync, top_value, stack_depth, output ready);
endinterface
`default_nettype wire

// File: src/stack_machine_execute_unit.sv
// stack machine execute unit
// instr channel: one word per instruction (opcode, immediate, receive status);
// result channel: one word per instruction (pc, run state, fault, io events,
// stack top and depth). config port: index 0 start address (also loads pc),
// index 1 program length; the user must write it only while idle (unchecked).
// state lives in three synchronous memories: data stack, return stack and
// word ram, each with one write and one registered read port.
// an instruction passes the read and execute states, then writes back its
// data stack entries (0 to 3) one at a time through the single write port,
// then finishes; divide first waits for the bit-serial divider.
// one instruction is in flight at a time; a finished result sits in the
// output register, and the next instruction cannot finish until it moves,
// so a stalled receiver stalls the block.
// after reset the word ram is cleared one entry per cycle, all MEMORY_WORDS
// entries, before the first instruction is accepted.
`default_nettype none
module stack_machine_execute_unit #(
  parameter int DATA_STACK_DEPTH   = smeu_pkg::DATA_STACK_DEPTH,
  parameter int RETURN_STACK_DEPTH = smeu_pkg::RETURN_STACK_DEPTH,
  parameter int MEMORY_WORDS       = smeu_pkg::MEMORY_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  smeu_in_if.sink          instr,
  smeu_out_if.source       result,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [31:0] wr_data
);
  import smeu_pkg::*;

  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_STACK_DEPTH);
  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int MAW = $clog2(MEMORY_WORDS);
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_LEN   = 1'b1;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_EX, S_DIV, S_WR, S_FIN} state_t;

  state_t st;
  logic [31:0] start_address, program_length;
  logic [31:0] pc, fp, tcmp, tctrl, top, d2;
  logic [31:0] csr [8];
  logic        km, stopped;
  logic [1:0]  run_code;
  logic [2:0]  fault;
  logic [DDW-1:0] depth;
  logic [RDW-1:0] rdepth;
  logic [MAW-1:0] clr_cnt, waddr;
  logic [7:0]  op;
  logic [31:0] imm;
  logic        rxa;
  logic [7:0]  rxb;
  logic [1:0]  nw, wk;
  logic [31:0] wslot [3];
  logic        ev_tx, ev_rx, ev_fs;
  logic [7:0]  ev_txb;

  logic [31:0] dmem [DATA_STACK_DEPTH];
  logic [31:0] rmem [RETURN_STACK_DEPTH];
  logic [31:0] wmem [MEMORY_WORDS];
  logic [31:0] dq, rq, wq;

  logic        accept;
  logic        o_valid;
  logic        div_done;
  logic [31:0] div_q;

  assign accept      = instr.valid && instr.ready;
  assign instr.ready = (st == S_IDLE);

  // data stack memory
  logic [DDW-1:0] d_raddr, d_waddr;
  logic           d_ren;
  always_comb begin
    d_raddr = (st == S_IDLE) ? depth - DDW'(2) : depth - DDW'(3);
    d_ren   = accept || (st == S_RD);
    d_waddr = depth - DDW'(1) - DDW'(wk);
  end
  always_ff @(posedge clk) begin
    if (st == S_WR) dmem[d_waddr[DAW-1:0]] <= wslot[wk];
    if (d_ren) dq <= dmem[d_raddr[DAW-1:0]];
  end

  // execute-stage combinational results
  op_info_t    inf;
  logic [2:0]  x_fault;
  logic        x_end;
  logic [DDW:0] dsum;
  logic [RDW:0] rsum;
  logic [31:0] x_pc, x_top, x_res, ld, mmio, bq, pc1, x_fp, x_tcmp, x_tctrl, x_cr0;
  logic [1:0]  x_nw;
  logic [31:0] x_w1, x_w2;
  logic        x_wwe, x_rwe, x_div, x_halt, x_km, x_tx, x_rx, x_fs;
  logic        x_cr_we, x_trap;
  logic [2:0]  x_cr_i;
  logic [31:0] x_cr_d, x_wwd, x_rwd;
  logic [7:0]  x_txb, i8;

  always_comb begin
    inf   = op_decode(op);
    i8    = imm[7:0];
    pc1   = pc + 32'd1;
    dsum  = {1'b0, depth} - (DDW+1)'(inf.dp) + (DDW+1)'(inf.dq);
    rsum  = {1'b0, rdepth} - (RDW+1)'(inf.rp) + (RDW+1)'(inf.rq);
    x_fault = F_NONE;
    if (!inf.legal) x_fault = F_ILLEGAL;
    else if (inf.imm == IMM_32 && ({1'b0, pc} + 33'd5 > {1'b0, program_length}))
      x_fault = F_IMM;
    else if (inf.imm == IMM_8 && ({1'b0, pc} + 33'd1 >= {1'b0, program_length}))
      x_fault = F_IMM;
    else if ({1'b0, depth} < (DDW+1)'(inf.dp)) x_fault = F_DUNDER;
    else if ({1'b0, rdepth} < (RDW+1)'(inf.rp)) x_fault = F_RUNDER;
    else if (dsum > (DDW+1)'(DATA_STACK_DEPTH)) x_fault = F_DOVER;
    else if (rsum > (RDW+1)'(RETURN_STACK_DEPTH)) x_fault = F_ROVER;
    x_end = (pc >= program_length);

    case (top)
      IO_RX:    mmio = rxa ? {24'd0, rxb} : 32'd0;
      IO_STAT:  mmio = {30'd0, rxa, 1'b1};
      IO_TCMP:  mmio = tcmp;
      IO_TCTRL: mmio = tctrl;
      default:  mmio = 32'd0;
    endcase
    ld = (top < IO_BASE) ? wq : mmio;
    bq = wq;
    case (top[1:0])
      2'd0:    bq[7:0]   = d2[7:0];
      2'd1:    bq[15:8]  = d2[7:0];
      2'd2:    bq[23:16] = d2[7:0];
      default: bq[31:24] = d2[7:0];
    endcase

    x_pc = pc1; x_res = 32'd0; x_nw = 2'd0; x_w1 = 32'd0; x_w2 = 32'd0;
    x_top = (dsum[DDW-1:0] == '0) ? 32'd0 : d2;
    x_wwe = 1'b0; x_wwd = top; x_rwe = 1'b0; x_rwd = pc1;
    x_div = 1'b0; x_halt = 1'b0; x_km = km; x_fp = fp; x_tcmp = tcmp; x_tctrl = tctrl;
    x_tx = 1'b0; x_txb = 8'd0; x_rx = 1'b0; x_fs = 1'b0;
    x_cr_we = 1'b0; x_cr_i = i8[2:0]; x_cr_d = top; x_trap = 1'b0; x_cr0 = csr[0];
    case (op)
      OP_PUSH:  begin x_pc = pc + 32'd5; x_res = imm; x_nw = 2'd1; end
      OP_ADD:   begin x_res = d2 + top; x_nw = 2'd1; end
      OP_SUB:   begin x_res = d2 - top; x_nw = 2'd1; end
      OP_MUL:   begin x_res = d2 * top; x_nw = 2'd1; end
      OP_DIV:   x_div = 1'b1;
      OP_PRINT: begin x_tx = 1'b1; x_txb = top[7:0]; end
      OP_EQ:    begin x_res = {31'd0, d2 == top}; x_nw = 2'd1; end
      OP_LT:    begin x_res = {31'd0, $signed(d2) < $signed(top)}; x_nw = 2'd1; end
      OP_GT:    begin x_res = {31'd0, $signed(d2) > $signed(top)}; x_nw = 2'd1; end
      OP_LTU:   begin x_res = {31'd0, d2 < top}; x_nw = 2'd1; end
      OP_GTU:   begin x_res = {31'd0, d2 > top}; x_nw = 2'd1; end
      OP_EQZ:   begin x_res = {31'd0, top == 32'd0}; x_nw = 2'd1; end
      OP_AND:   begin x_res = d2 & top; x_nw = 2'd1; end
      OP_OR:    begin x_res = d2 | top; x_nw = 2'd1; end
      OP_XOR:   begin x_res = d2 ^ top; x_nw = 2'd1; end
      OP_NOT:   begin x_res = ~top; x_nw = 2'd1; end
      OP_SHL:   begin x_res = d2 << top[4:0]; x_nw = 2'd1; end
      OP_SHR:   begin x_res = d2 >> top[4:0]; x_nw = 2'd1; end
      OP_SAR:   begin x_res = 32'($signed(d2) >>> top[4:0]); x_nw = 2'd1; end
      OP_DUP:   begin x_res = top; x_nw = 2'd1; end
      OP_OVER:  begin x_res = d2; x_nw = 2'd1; end
      OP_SWAP:  begin x_res = d2; x_w1 = top; x_nw = 2'd2; end
      OP_ROT:   begin x_res = dq; x_w1 = top; x_w2 = d2; x_nw = 2'd3; end
      OP_DEPTH: begin x_res = 32'(depth); x_nw = 2'd1; end
      OP_RDEPTH: begin x_res = 32'(rdepth); x_nw = 2'd1; end
      OP_LOAD:  begin x_res = ld; x_nw = 2'd1; x_rx = (top == IO_RX) && rxa; end
      OP_LOADB: begin
        x_res = {24'd0, 8'(ld >> {top[1:0], 3'b000})};
        x_nw = 2'd1; x_rx = (top == IO_RX) && rxa;
      end
      OP_STORE: begin
        x_wwd = d2;
        if (top < IO_BASE) x_wwe = 1'b1;
        else if (top == IO_TX) begin x_tx = 1'b1; x_txb = d2[7:0]; end
        else if (top == IO_TCMP) x_tcmp = d2;
        else if (top == IO_TCTRL) x_tctrl = d2;
      end
      OP_STOREB: begin
        x_wwd = bq;
        if (top == FRAME_ADDR) x_fs = 1'b1;
        else if (top < IO_BASE) x_wwe = 1'b1;
        else if (top == IO_TX) begin x_tx = 1'b1; x_txb = d2[7:0]; end
        else if (top == IO_TCMP) x_tcmp = {24'd0, d2[7:0]};
        else if (top == IO_TCTRL) x_tctrl = {24'd0, d2[7:0]};
      end
      OP_LDL:   begin x_pc = pc + 32'd2; x_res = wq; x_nw = 2'd1; end
      OP_STL:   begin x_pc = pc + 32'd2; x_wwe = 1'b1; x_wwd = top; end
      OP_JNZ:   x_pc = (top != 32'd0) ? imm : pc + 32'd5;
      OP_JMP:   x_pc = imm;
      OP_CALL:  begin x_pc = imm; x_rwe = 1'b1; x_rwd = pc + 32'd5; end
      OP_RET:   x_pc = rq;
      OP_KEY:   begin x_res = rxa ? {24'd0, rxb} : 32'd0; x_rx = rxa; x_nw = 2'd1; end
      OP_TOR:   begin x_rwe = 1'b1; x_rwd = top; end
      OP_FROMR, OP_RFETCH: begin x_res = rq; x_nw = 2'd1; end
      OP_SYSENTER: begin
        x_trap = 1'b1; x_km = 1'b1;
        x_cr0 = (csr[0] | ST_KM) & ~ST_UM;
        if (csr[2] != 32'd0) x_pc = csr[2] + TRAP_OFFSET;
      end
      OP_ERET: begin
        x_cr0 = (csr[0] & ~ST_KM) | ST_UM; x_km = 1'b0; x_pc = csr[3];
      end
      OP_CSRR: begin
        x_pc = pc + 32'd5; x_nw = 2'd1;
        x_res = (i8[7:3] == 5'd0) ? csr[i8[2:0]] : 32'd0;
      end
      OP_CSRW: begin
        x_pc = pc + 32'd5;
        if (i8[7:3] == 5'd0) begin
          x_cr_we = 1'b1;
          if (i8[2:0] == 3'd0) x_km = top[0];
        end
      end
      OP_GETFP: begin x_res = fp; x_nw = 2'd1; end
      OP_SETFP: x_fp = top;
      OP_CALLI: begin x_pc = top; x_rwe = 1'b1; x_rwd = pc1; end
      OP_HALT:  x_halt = 1'b1;
      default: ;
    endcase
    if (x_nw != 2'd0) x_top = x_res;
    else if (inf.dp == inf.dq) x_top = top;
  end

  // return stack memory
  logic [RDW-1:0] r_raddr;
  assign r_raddr = rdepth - RDW'(1);
  always_ff @(posedge clk) begin
    if (st == S_EX && !stopped && !x_end && x_fault == F_NONE && x_rwe)
      rmem[rdepth[RAW-1:0]] <= x_rwd;
    if (accept) rq <= rmem[r_raddr[RAW-1:0]];
  end

  // word ram
  logic [MAW-1:0] w_raddr, w_addr;
  logic [31:0]    fp_sum, w_wd;
  logic           w_we;
  always_comb begin
    fp_sum  = fp + {24'd0, instr.immediate[7:0]};
    w_raddr = (instr.opcode == OP_LDL || instr.opcode == OP_STL) ?
              fp_sum[MAW-1:0] : top[MAW+1:2];
    w_we    = (st == S_CLR) ||
              (st == S_EX && !stopped && !x_end && x_fault == F_NONE && x_wwe);
    w_addr  = (st == S_CLR) ? clr_cnt : waddr;
    w_wd    = (st == S_CLR) ? 32'd0 : x_wwd;
  end
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_addr] <= w_wd;
    if (accept) wq <= wmem[w_raddr];
  end

  smeu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (st == S_EX && !stopped && !x_end && x_fault == F_NONE && x_div),
    .dividend (d2),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR; clr_cnt <= '0;
      start_address <= 32'd0; program_length <= 32'd0; pc <= 32'd0;
      depth <= '0; rdepth <= '0; fp <= 32'd0; top <= 32'd0;
      for (int k = 0; k < 8; k++) csr[k] <= 32'd0;
      csr[0] <= ST_KM; km <= 1'b1;
      tcmp <= 32'd0; tctrl <= 32'd0;
      stopped <= 1'b0; run_code <= RUN_GO; fault <= F_NONE;
      nw <= 2'd0; wk <= 2'd0; o_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        if (wr_index == CFG_START) begin
          start_address <= wr_data; pc <= wr_data;
        end else if (wr_index == CFG_LEN) program_length <= wr_data;
      end
      if (o_valid && result.ready) o_valid <= 1'b0;
      case (st)
        S_CLR: begin
          clr_cnt <= clr_cnt + MAW'(1);
          if (clr_cnt == '1) st <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op <= instr.opcode; imm <= instr.immediate;
            rxa <= instr.rx_available; rxb <= instr.rx_byte;
            waddr <= w_raddr;
            st <= S_RD;
          end
        end
        S_RD: begin
          d2 <= dq;
          st <= S_EX;
        end
        S_EX: begin
          ev_tx <= 1'b0; ev_txb <= 8'd0; ev_rx <= 1'b0; ev_fs <= 1'b0;
          nw <= 2'd0; wk <= 2'd0;
          st <= S_FIN;
          if (!stopped) begin
            if (x_end) begin
              stopped <= 1'b1; run_code <= RUN_END;
            end else if (x_fault != F_NONE) begin
              stopped <= 1'b1; run_code <= RUN_GO; fault <= x_fault;
            end else begin
              ev_tx <= x_tx; ev_txb <= x_txb; ev_rx <= x_rx; ev_fs <= x_fs;
              pc <= x_pc; depth <= dsum[DDW-1:0]; rdepth <= rsum[RDW-1:0];
              top <= x_top; fp <= x_fp; tcmp <= x_tcmp; tctrl <= x_tctrl; km <= x_km;
              wslot[0] <= x_res; wslot[1] <= x_w1; wslot[2] <= x_w2; nw <= x_nw;
              csr[0] <= x_cr0;
              if (x_trap) begin
                csr[3] <= pc; csr[4] <= top;
              end
              if (x_cr_we) csr[x_cr_i] <= x_cr_d;
              if (x_halt) begin
                stopped <= 1'b1; run_code <= RUN_HALT;
              end else if (x_pc >= program_length) begin
                stopped <= 1'b1; run_code <= RUN_END;
              end
              if (x_div) st <= S_DIV;
              else if (x_nw != 2'd0) st <= S_WR;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            wslot[0] <= div_q; top <= div_q; nw <= 2'd1;
            st <= S_WR;
          end
        end
        S_WR: begin
          if (wk == nw - 2'd1) st <= S_FIN;
          else wk <= wk + 2'd1;
        end
        S_FIN: begin
          if (!o_valid || result.ready) begin
            o_valid <= 1'b1;
            result.next_pc <= pc;
            result.run_state <= run_code;
            result.fault_code <= fault;
            result.tx_valid <= ev_tx;
            result.tx_byte <= ev_txb;
            result.rx_taken <= ev_rx;
            result.frame_sync <= ev_fs;
            result.top_value <= top;
            result.stack_depth <= DEPTH_W'(depth);
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign result.valid = o_valid;

endmodule
`default_nettype wire

// File: src/smeu_div.sv
`default_nettype none
module smeu_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  import smeu_pkg::*;

  localparam int CW = $clog2(WORD_W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [32:0]   rem;
  logic [31:0]   quot;
  logic [31:0]   dsr;
  logic          neg;
  logic          zero;
  logic [32:0]   shifted;
  logic [32:0]   trial;

  assign shifted = {rem[31:0], quot[31]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_W);
        rem  <= '0;
        quot <= dividend[31] ? (32'd0 - dividend) : dividend;
        dsr  <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg  <= dividend[31] ^ divisor[31];
        zero <= (divisor == 32'd0);
      end else if (busy) begin
        if (cnt == '0) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= zero ? 32'd0 : (neg ? (32'd0 - quot) : quot);
        end else begin
          cnt  <= cnt - CW'(1);
          rem  <= trial[32] ? shifted : trial;
          quot <= {quot[30:0], ~trial[32]};
        end
      end
    end
  end
endmodule
`default_nettype wire
